[sv/ndr_pkg.sv]
`timescale 1ns / 1ps

package ndr_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_VARS_DEF = 8;

    localparam int WORD_W      = 64;
    localparam int NUM_VARS_W  = 4;
    localparam int ROW_IDX_W   = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_word;
        logic clr_set;
        logic cnt_step;
        logic i_init;
        logic i_next;
        logic j_init;
        logic j_next;
        logic m_init;
        logic m_next;
        logic rd_cols;
        logic rd_const;
        logic fpu_start;
        logic mark_i;
        logic mark_j;
        logic emit_init;
        logic emit_next;
    } ndr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_more;
        logic rows_zero;
        logic rows_le1;
        logic i_end;
        logic i_removed;
        logic j_end;
        logic j_removed;
        logic m_last;
        logic fpu_done;
        logic fpu_differ;
        logic const_le;
        logic emit_last;
    } ndr_stat_t;

endpackage

[sv/ndr_in_if.sv]
`timescale 1ns / 1ps

interface ndr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] coefficient;
    logic        final_req;

    modport source (output valid, output coefficient, output final_req, input ready);
    modport sink (input valid, input coefficient, input final_req, output ready);
endinterface

[sv/ndr_out_if.sv]
`timescale 1ns / 1ps

interface ndr_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] row_index;
    logic       keep;
    logic       last;
    logic       overflow;

    modport source (output valid, output row_index, output keep, output last,
                    output overflow, input ready);
    modport sink (input valid, input row_index, input keep, input last,
                  input overflow, output ready);
endinterface

[sv/ndr_fpu.sv]
`timescale 1ns / 1ps

// Decides whether two coefficient words differ: a rounded double subtraction of the
// magnitudes, a restoring division by the larger magnitude, then a compare with epsilon.
module ndr_fpu
    import ndr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    input  logic [63:0] y,
    input  logic [63:0] eps,
    output logic        done,
    output logic        differ
);

    typedef enum logic [9:0] {
        F_IDLE   = 10'b0000000001,
        F_ALIGN  = 10'b0000000010,
        F_SUB    = 10'b0000000100,
        F_NORM   = 10'b0000001000,
        F_ROUND  = 10'b0000010000,
        F_DNORM  = 10'b0000100000,
        F_DSETUP = 10'b0001000000,
        F_DIV    = 10'b0010000000,
        F_PACK   = 10'b0100000000,
        F_CMP    = 10'b1000000000
    } fpu_state_t;

    fpu_state_t         state_reg, state_next;
    logic               done_reg, done_next;
    logic               differ_reg, differ_next;
    logic [52:0]        mb_reg, mb_next;
    logic signed [12:0] eb_reg, eb_next;
    logic [52:0]        ms_reg, ms_next;
    logic [11:0]        k_reg, k_next;
    logic [55:0]        sal_reg, sal_next;
    logic [55:0]        r_reg, r_next;
    logic signed [12:0] e_reg, e_next;
    logic [52:0]        md_reg, md_next;
    logic signed [12:0] qe_reg, qe_next;
    logic [54:0]        rem_reg, rem_next;
    logic [53:0]        qr_reg, qr_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [62:0]        q_reg, q_next;
    logic [63:0]        eps_reg, eps_next;

    logic        xnan, ynan, xz, yz, x_big;
    logic [62:0] big, lesser;
    logic [55:0] sh, lostmask;
    logic        lost;
    logic [53:0] rsum;
    logic        lt;
    logic [53:0] nq;
    logic signed [12:0] qe_c;
    logic        ge;
    logic [54:0] dv;
    logic        up;
    logic [10:0] expf;
    logic        epsnan;

    assign xnan   = (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
    assign ynan   = (y[62:52] == 11'h7ff) && (y[51:0] != 52'd0);
    assign xz     = (x[62:0] == 63'd0);
    assign yz     = (y[62:0] == 63'd0);
    assign x_big  = (x[62:0] > y[62:0]);
    assign big    = x_big ? x[62:0] : y[62:0];
    assign lesser = x_big ? y[62:0] : x[62:0];

    assign sh       = {ms_reg, 3'b000} >> k_reg[5:0];
    assign lostmask = ~({56{1'b1}} << k_reg[5:0]);
    assign lost     = |({ms_reg, 3'b000} & lostmask);

    assign rsum = {1'b0, r_reg[55:3]} + {53'd0, r_reg[2] & (r_reg[3] | r_reg[1] | r_reg[0])};

    assign lt   = (md_reg < mb_reg);
    assign nq   = lt ? {md_reg, 1'b0} : {1'b0, md_reg};
    assign qe_c = e_reg - eb_reg - $signed({12'd0, lt}) + 13'sd1023;

    assign ge = (rem_reg >= {2'b00, mb_reg});
    assign dv = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;

    assign up   = qr_reg[0] & ((rem_reg != 55'd0) | qr_reg[1]);
    assign expf = (qe_reg >= 13'sd1) ? 11'(qe_reg - 13'sd1) : 11'd0;

    assign epsnan = (eps_reg[62:52] == 11'h7ff) && (eps_reg[51:0] != 52'd0);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        differ_next = differ_reg;
        mb_next     = mb_reg;
        eb_next     = eb_reg;
        ms_next     = ms_reg;
        k_next      = k_reg;
        sal_next    = sal_reg;
        r_next      = r_reg;
        e_next      = e_reg;
        md_next     = md_reg;
        qe_next     = qe_reg;
        rem_next    = rem_reg;
        qr_next     = qr_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        eps_next    = eps_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    eps_next = eps;
                    mb_next  = {big[62:52] != 11'd0, big[51:0]};
                    eb_next  = (big[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, big[62:52]});
                    ms_next  = {lesser[62:52] != 11'd0, lesser[51:0]};
                    k_next   = 12'((big[62:52] == 11'd0 ? 11'd1 : big[62:52])
                               - (lesser[62:52] == 11'd0 ? 11'd1 : lesser[62:52]));
                    if (xnan || ynan || (x == y) || (xz && yz))
                    begin
                        done_next   = 1'b1;
                        differ_next = 1'b0;
                    end
                    else if ((x[63] != y[63]) && !xz && !yz)
                    begin
                        done_next   = 1'b1;
                        differ_next = 1'b1;
                    end
                    else if (big[62:52] == 11'h7ff)
                    begin
                        // An infinite magnitude makes the ratio a not-a-number.
                        done_next   = 1'b1;
                        differ_next = 1'b0;
                    end
                    else
                    begin
                        state_next = F_ALIGN;
                    end
                end
            end
            F_ALIGN:
            begin
                if (k_reg >= 12'd56)
                    sal_next = {55'd0, |ms_reg};
                else
                    sal_next = {sh[55:1], sh[0] | lost};
                state_next = F_SUB;
            end
            F_SUB:
            begin
                r_next     = {mb_reg, 3'b000} - sal_reg;
                e_next     = eb_reg;
                state_next = F_NORM;
            end
            F_NORM:
            begin
                if (!r_reg[55] && (e_reg > 13'sd1))
                begin
                    r_next = {r_reg[54:0], 1'b0};
                    e_next = e_reg - 13'sd1;
                end
                else
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND:
            begin
                if (rsum[53])
                begin
                    md_next = rsum[53:1];
                    e_next  = e_reg + 13'sd1;
                end
                else
                begin
                    md_next = rsum[52:0];
                end
                state_next = F_DNORM;
            end
            F_DNORM:
            begin
                if (md_reg[52] && mb_reg[52])
                begin
                    state_next = F_DSETUP;
                end
                else
                begin
                    if (!md_reg[52])
                    begin
                        md_next = {md_reg[51:0], 1'b0};
                        e_next  = e_reg - 13'sd1;
                    end
                    if (!mb_reg[52])
                    begin
                        mb_next = {mb_reg[51:0], 1'b0};
                        eb_next = eb_reg - 13'sd1;
                    end
                end
            end
            F_DSETUP:
            begin
                qe_next  = qe_c;
                rem_next = {1'b0, nq};
                qr_next  = 54'd0;
                if (qe_c >= 13'sd1)
                begin
                    cnt_next   = 6'd54;
                    state_next = F_DIV;
                end
                else if (qe_c >= -13'sd52)
                begin
                    cnt_next   = 6'(qe_c + 13'sd53);
                    state_next = F_DIV;
                end
                else
                begin
                    // The quotient rounds to zero.
                    q_next     = 63'd0;
                    state_next = F_CMP;
                end
            end
            F_DIV:
            begin
                qr_next  = {qr_reg[52:0], ge};
                rem_next = {dv[53:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = F_PACK;
            end
            F_PACK:
            begin
                q_next     = {expf, 52'd0} + {10'd0, qr_reg[53:1]} + {62'd0, up};
                state_next = F_CMP;
            end
            F_CMP:
            begin
                if (epsnan)
                    differ_next = 1'b0;
                else if (eps_reg[63])
                    differ_next = (q_reg != 63'd0) || (eps_reg[62:0] != 63'd0);
                else
                    differ_next = (q_reg > eps_reg[62:0]);
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            done_reg   <= 1'b0;
            differ_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            differ_reg <= differ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mb_reg  <= mb_next;
        eb_reg  <= eb_next;
        ms_reg  <= ms_next;
        k_reg   <= k_next;
        sal_reg <= sal_next;
        r_reg   <= r_next;
        e_reg   <= e_next;
        md_reg  <= md_next;
        qe_reg  <= qe_next;
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        eps_reg <= eps_next;
    end

    assign done   = done_reg;
    assign differ = differ_reg;

endmodule

[sv/ndr_datapath.sv]
`timescale 1ns / 1ps

module ndr_datapath
    import ndr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_VARS = MAX_VARS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [WORD_W-1:0]     coefficient,
    input  ndr_cmd_t              cmd,
    output ndr_stat_t             stat,
    output logic [ROW_IDX_W-1:0]  row_index,
    output logic                  keep,
    output logic                  last,
    output logic                  overflow
);

    localparam int DEPTH = MAX_ROWS * (2 * MAX_VARS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(2 * MAX_VARS + 2);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int IW    = $clog2(MAX_ROWS);

    logic [NUM_VARS_W-1:0] num_vars_reg;
    logic [WORD_W-1:0]     tol_reg;
    logic [BW-1:0]         word_count_reg;
    logic                  ovf_reg;
    logic [RW-1:0]         rows_reg;
    logic [RW-1:0]         i_reg;
    logic [RW-1:0]         j_reg;
    logic [RW-1:0]         erow_reg;
    logic [BW-1:0]         base_i_reg;
    logic [BW-1:0]         base_j_reg;
    logic [LW-1:0]         m_reg;
    logic [MAX_ROWS-1:0]   removed_reg;
    logic [WORD_W-1:0]     rd_a_reg;
    logic [WORD_W-1:0]     rd_b_reg;
    logic [WORD_W-1:0]     mem [DEPTH];

    logic [LW-1:0]  len;
    logic [BW-1:0]  cap;
    logic           store_ok;
    logic [BW-1:0]  addr_a, addr_b;
    logic           fpu_done, fpu_differ;
    logic           a_nan, b_nan;
    logic [63:0]    key_a, key_b;

    always_comb
    begin
        if (num_vars_reg == '0)
            len = LW'(3);
        else if (32'(num_vars_reg) > MAX_VARS)
            len = LW'(2 * MAX_VARS + 1);
        else
            len = LW'({num_vars_reg, 1'b1});
    end

    assign cap      = BW'(MAX_ROWS * 32'(len));
    assign store_ok = (word_count_reg < cap);
    assign addr_a   = cmd.rd_const ? base_i_reg : base_i_reg + BW'(m_reg);
    assign addr_b   = cmd.rd_const ? base_j_reg : base_j_reg + BW'(m_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= NUM_VARS_W'(1);
            tol_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_VARS:  num_vars_reg <= cfg_data[NUM_VARS_W-1:0];
                CFG_TOLERANCE: tol_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            ovf_reg        <= 1'b0;
            rows_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            erow_reg       <= '0;
            base_i_reg     <= '0;
            base_j_reg     <= '0;
            m_reg          <= '0;
            removed_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_set)
            begin
                word_count_reg <= '0;
                ovf_reg        <= 1'b0;
                rows_reg       <= '0;
                removed_reg    <= '0;
            end
            if (cmd.load_word)
            begin
                if (store_ok)
                    word_count_reg <= word_count_reg + BW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.cnt_step)
            begin
                word_count_reg <= word_count_reg - BW'(len);
                rows_reg       <= rows_reg + RW'(1);
            end
            if (cmd.i_init)
            begin
                i_reg      <= '0;
                base_i_reg <= '0;
            end
            if (cmd.i_next)
            begin
                i_reg      <= i_reg + RW'(1);
                base_i_reg <= base_i_reg + BW'(len);
            end
            if (cmd.j_init)
            begin
                j_reg      <= i_reg + RW'(1);
                base_j_reg <= base_i_reg + BW'(len);
            end
            if (cmd.j_next)
            begin
                j_reg      <= j_reg + RW'(1);
                base_j_reg <= base_j_reg + BW'(len);
            end
            if (cmd.m_init)
                m_reg <= LW'(1);
            if (cmd.m_next)
                m_reg <= m_reg + LW'(1);
            if (cmd.mark_i)
                removed_reg[i_reg[IW-1:0]] <= 1'b1;
            if (cmd.mark_j)
                removed_reg[j_reg[IW-1:0]] <= 1'b1;
            if (cmd.emit_init)
                erow_reg <= '0;
            if (cmd.emit_next)
                erow_reg <= erow_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_word && store_ok)
            mem[word_count_reg[AW-1:0]] <= coefficient;
        if (cmd.rd_cols || cmd.rd_const)
        begin
            rd_a_reg <= mem[addr_a[AW-1:0]];
            rd_b_reg <= mem[addr_b[AW-1:0]];
        end
    end

    ndr_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .x      (rd_a_reg),
        .y      (rd_b_reg),
        .eps    (tol_reg),
        .done   (fpu_done),
        .differ (fpu_differ)
    );

    // Ordered compare of the two constants; either one a not-a-number gives false.
    assign a_nan = (rd_a_reg[62:52] == 11'h7ff) && (rd_a_reg[51:0] != 52'd0);
    assign b_nan = (rd_b_reg[62:52] == 11'h7ff) && (rd_b_reg[51:0] != 52'd0);
    assign key_a = rd_a_reg[63] ? ~rd_a_reg : {1'b1, rd_a_reg[62:0]};
    assign key_b = rd_b_reg[63] ? ~rd_b_reg : {1'b1, rd_b_reg[62:0]};

    always_comb
    begin
        stat.cnt_more   = (word_count_reg >= BW'(len)) && (32'(rows_reg) < MAX_ROWS);
        stat.rows_zero  = (rows_reg == '0);
        stat.rows_le1   = (rows_reg <= RW'(1));
        stat.i_end      = ((i_reg + RW'(1)) >= rows_reg);
        stat.i_removed  = removed_reg[i_reg[IW-1:0]];
        stat.j_end      = (j_reg >= rows_reg);
        stat.j_removed  = removed_reg[j_reg[IW-1:0]];
        stat.m_last     = ((m_reg + LW'(1)) == len);
        stat.fpu_done   = fpu_done;
        stat.fpu_differ = fpu_differ;
        if (a_nan || b_nan)
            stat.const_le = 1'b0;
        else if ((rd_a_reg[62:0] == 63'd0) && (rd_b_reg[62:0] == 63'd0))
            stat.const_le = 1'b1;
        else
            stat.const_le = (key_a <= key_b);
        stat.emit_last  = ((erow_reg + RW'(1)) == rows_reg);
    end

    assign row_index = ROW_IDX_W'(erow_reg);
    assign keep      = !removed_reg[erow_reg[IW-1:0]];
    assign last      = stat.emit_last;
    assign overflow  = ovf_reg;

endmodule

[sv/ndr_ctrl.sv]
`timescale 1ns / 1ps

module ndr_ctrl
    import ndr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_final,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ndr_stat_t stat,
    output ndr_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_LOAD      = 11'b00000000001,
        S_COUNT     = 11'b00000000010,
        S_NEXT_I    = 11'b00000000100,
        S_NEXT_J    = 11'b00000001000,
        S_RD        = 11'b00000010000,
        S_CMP_START = 11'b00000100000,
        S_CMP_WAIT  = 11'b00001000000,
        S_CONST_RD  = 11'b00010000000,
        S_DECIDE    = 11'b00100000000,
        S_EMIT      = 11'b01000000000,
        S_FINISH    = 11'b10000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready      = 1'b1;
                cmd.load_word = in_valid;
                if (in_valid && in_final)
                    state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (stat.cnt_more)
                    cmd.cnt_step = 1'b1;
                else if (stat.rows_zero)
                    state_next = S_FINISH;
                else if (stat.rows_le1)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.i_init = 1'b1;
                    state_next = S_NEXT_I;
                end
            end
            S_NEXT_I:
            begin
                if (stat.i_end)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (stat.i_removed)
                    cmd.i_next = 1'b1;
                else
                begin
                    cmd.j_init = 1'b1;
                    state_next = S_NEXT_J;
                end
            end
            S_NEXT_J:
            begin
                if (stat.j_end)
                begin
                    cmd.i_next = 1'b1;
                    state_next = S_NEXT_I;
                end
                else if (stat.j_removed)
                    cmd.j_next = 1'b1;
                else
                begin
                    cmd.m_init = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_cols = 1'b1;
                state_next  = S_CMP_START;
            end
            S_CMP_START:
            begin
                cmd.fpu_start = 1'b1;
                state_next    = S_CMP_WAIT;
            end
            S_CMP_WAIT:
            begin
                if (stat.fpu_done)
                begin
                    if (stat.fpu_differ)
                    begin
                        cmd.j_next = 1'b1;
                        state_next = S_NEXT_J;
                    end
                    else if (stat.m_last)
                        state_next = S_CONST_RD;
                    else
                    begin
                        cmd.m_next = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_CONST_RD:
            begin
                cmd.rd_const = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.const_le)
                begin
                    cmd.mark_j = 1'b1;
                    cmd.j_next = 1'b1;
                    state_next = S_NEXT_J;
                end
                else
                begin
                    cmd.mark_i = 1'b1;
                    cmd.i_next = 1'b1;
                    state_next = S_NEXT_I;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.emit_last)
                        state_next = S_FINISH;
                    else
                        cmd.emit_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.clr_set = 1'b1;
                state_next  = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

[sv/near_duplicate_row_removal_top.sv]
`timescale 1ns / 1ps
// Near-duplicate constraint row removal.
// The in_ch channel takes one IEEE double word per transaction, row-major, each row
// a constant and then 2*num_vars coefficients. The transaction with final_req set
// ends the set and starts the pairwise scan. Words are taken one per cycle while the
// block is loading; in_ch.ready stays low from the final word until the last verdict.
// The out_ch channel then gives one verdict per complete row in ascending order, with
// keep, last on the final row, and overflow when words beyond capacity were dropped.
// Rows are counted first; then each compared column passes through the one iterative
// subtract-and-divide unit that all columns share. It finishes early when the words are
// equal, not-a-number, infinite or of opposite sign, and takes longest under heavy
// cancellation or with subnormal words.
// Each verdict waits on out_ch.ready and holds while the receiver stalls.
// Configuration is a plain write port and is meant to be written between sets.
// Reset returns the block to loading with an empty set; the word store is not
// cleared and only words of the current set are ever read.
module near_duplicate_row_removal_top
    import ndr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_VARS = MAX_VARS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ndr_in_if.sink                in_ch,
    ndr_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ndr_cmd_t  cmd;
    ndr_stat_t stat;

    // The controller sequences loading, row counting, the pair scan and the verdicts.
    ndr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_final  (in_ch.final_req),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the word store, counters, removal marks and compare unit.
    ndr_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_VARS (MAX_VARS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coefficient (in_ch.coefficient),
        .cmd         (cmd),
        .stat        (stat),
        .row_index   (out_ch.row_index),
        .keep        (out_ch.keep),
        .last        (out_ch.last),
        .overflow    (out_ch.overflow)
    );

endmodule

[dv/tb_near_duplicate_row_removal_top.sv]
`timescale 1ns / 1ps

module tb_near_duplicate_row_removal_top;
    import ndr_pkg::*;

    localparam int ROWS_CAP   = 64;
    localparam int VARS_CAP   = 8;
    localparam int STORE_WORDS = ROWS_CAP * (2 * VARS_CAP + 1);
    localparam int CYCLE_LIMIT = 4_000_000;
    // Long enough for row counting and any other tail activity to finish.
    localparam int SETTLE_CYCLES = 200;

    // IEEE double bit patterns used by the directed transactions.
    localparam logic [63:0] D_ONE  = 64'h3FF0000000000000;
    localparam logic [63:0] D_TWO  = 64'h4000000000000000;
    localparam logic [63:0] D_NEG1 = 64'hBFF0000000000000;
    localparam logic [63:0] D_PZ   = 64'h0000000000000000;
    localparam logic [63:0] D_NZ   = 64'h8000000000000000;
    localparam logic [63:0] D_PINF = 64'h7FF0000000000000;
    localparam logic [63:0] D_QNAN = 64'h7FF8000000000000;
    localparam logic [63:0] D_ALL1 = 64'hFFFFFFFFFFFFFFFF;
    localparam logic [63:0] D_HALF = 64'h3FE0000000000000;
    localparam logic [63:0] D_MILLI = 64'h3F50624DD2F1A9FC;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic                 keep;
        logic                 last;
        logic                 overflow;
    } verdict_t;

    // One directed transaction. When typed_count is not negative, the expected
    // verdicts of the set are written out here instead of coming from the predictor.
    typedef struct {
        logic [63:0] word;
        bit          fin;
        int          typed_count;
        bit          typed_keep;
    } directed_word_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ndr_in_if  in_ch();
    ndr_out_if out_ch();

    near_duplicate_row_removal_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a private copy of the registers and of the current set.
    logic [3:0]  vars_reg;
    logic [63:0] eps_reg;
    logic [63:0] set_words [STORE_WORDS];
    int          set_count;
    bit          set_overflow;

    verdict_t expected_verdicts [$];
    verdict_t fresh_verdicts [$];
    int  error_count;
    int  cycle_count;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  words_sent;

    always #5 clk = ~clk;

    // The watchdog: a hung handshake must not keep the run going forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d verdicts still expected", $time,
                     expected_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idle rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Every verdict transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected verdict row %0d keep %0b last %0b overflow %0b",
                         $time, out_ch.row_index, out_ch.keep, out_ch.last,
                         out_ch.overflow);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (out_ch.row_index !== want.row_index)
                begin
                    error_count++;
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row_index, out_ch.row_index);
                end
                if (out_ch.keep !== want.keep)
                begin
                    error_count++;
                    $display("%0t: keep of row %0d expected %0b actual %0b", $time,
                             want.row_index, want.keep, out_ch.keep);
                end
                if (out_ch.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last of row %0d expected %0b actual %0b", $time,
                             want.row_index, want.last, out_ch.last);
                end
                if (out_ch.overflow !== want.overflow)
                begin
                    error_count++;
                    $display("%0t: overflow of row %0d expected %0b actual %0b", $time,
                             want.row_index, want.overflow, out_ch.overflow);
                end
            end
        end
    end

    function automatic int row_length();
        int nv;
        nv = (vars_reg == 0) ? 1 : ((vars_reg > VARS_CAP) ? VARS_CAP : int'(vars_reg));
        return 2 * nv + 1;
    endfunction

    function automatic real magnitude_of(real x);
        return (x < 0.0) ? -x : x;
    endfunction

    // The larger magnitude ignores a NaN operand.
    function automatic real larger_of(real a, real b);
        if (a != a)
            return b;
        if (b != b)
            return a;
        return (a > b) ? a : b;
    endfunction

    // True when every coefficient column of rows a and b is within tolerance.
    function automatic bit columns_match(int a, int b, int len, real eps);
        real x;
        real y;
        real d;
        real mx;
        for (int m = 1; m < len; m++)
        begin
            x = $bitstoreal(set_words[a * len + m]);
            y = $bitstoreal(set_words[b * len + m]);
            if (x == y)
                continue;
            if ((x > 0.0 && y < 0.0) || (x < 0.0 && y > 0.0))
                return 0;
            d  = (x >= y) ? x - y : y - x;
            mx = larger_of(magnitude_of(x), magnitude_of(y));
            if (mx == 0.0)
            begin
                if (d > eps)
                    return 0;
            end
            else if (d / mx > eps)
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    // Takes one accepted word; on the final word it fills fresh_verdicts with the
    // keep verdict of every complete row and starts a new set.
    task automatic predict_word(input logic [63:0] word, input bit fin);
        int  len;
        int  rows;
        real eps;
        bit  removed [ROWS_CAP];
        verdict_t v;
        len = row_length();
        fresh_verdicts.delete();
        if (set_count < ROWS_CAP * len)
        begin
            set_words[set_count] = word;
            set_count++;
        end
        else
        begin
            set_overflow = 1;
        end
        if (!fin)
            return;
        rows = set_count / len;
        eps  = $bitstoreal(eps_reg);
        foreach (removed[k])
            removed[k] = 0;
        for (int i = 0; i + 1 < rows; i++)
        begin
            if (removed[i])
                continue;
            for (int j = i + 1; j < rows; j++)
            begin
                if (removed[j] || !columns_match(i, j, len, eps))
                    continue;
                // A false comparison, as with a NaN constant, removes the earlier row.
                if ($bitstoreal(set_words[i * len]) <= $bitstoreal(set_words[j * len]))
                begin
                    removed[j] = 1;
                end
                else
                begin
                    removed[i] = 1;
                    break;
                end
            end
        end
        for (int i = 0; i < rows; i++)
        begin
            v.row_index = i[ROW_IDX_W-1:0];
            v.keep      = !removed[i];
            v.last      = (i + 1 == rows);
            v.overflow  = set_overflow;
            fresh_verdicts.push_back(v);
        end
        set_count    = 0;
        set_overflow = 0;
    endtask

    // Offers one word and holds it until the block takes it; then idles at random,
    // drawing afresh before each idle cycle.
    task automatic send_word(input logic [63:0] word, input bit fin);
        in_ch.valid       <= 1'b1;
        in_ch.coefficient <= word;
        in_ch.final_req   <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_word(word, fin);
        words_sent++;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_predicted(input logic [63:0] word, input bit fin);
        send_word(word, fin);
        foreach (fresh_verdicts[k])
            expected_verdicts.push_back(fresh_verdicts[k]);
    endtask

    // Waits until the block has nothing left to report, then lets it settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_NUM_VARS)
            vars_reg = value[3:0];
        else
            eps_reg = value;
    endtask

    // New settings, always applied with the block idle.
    task automatic reconfigure();
        logic [63:0] eps_pick;
        logic [3:0]  vars_pick;
        drain();
        case ($urandom_range(0, 7))
            0: vars_pick = 4'd0;
            1: vars_pick = 4'd15;
            2: vars_pick = 4'd8;
            default: vars_pick = 4'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 7))
            0: eps_pick = D_PZ;
            1: eps_pick = D_ALL1;
            2: eps_pick = D_PINF;
            3: eps_pick = D_NEG1;
            4: eps_pick = {$urandom, $urandom};
            5: eps_pick = D_HALF;
            default: eps_pick = D_MILLI;
        endcase
        write_register(CFG_NUM_VARS, {60'd0, vars_pick});
        write_register(CFG_TOLERANCE, eps_pick);
    endtask

    function automatic logic [63:0] random_special();
        case ($urandom_range(0, 7))
            0: return D_PZ;
            1: return D_NZ;
            2: return D_PINF;
            3: return D_QNAN;
            4: return D_ALL1;
            5: return D_ONE;
            6: return D_NEG1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A set of up to five rows, each after the first mostly a close copy of an earlier
    // row, so that the scan reaches the tolerance test and the removal decisions.
    task automatic send_random_set();
        int len;
        int rows;
        int extra;
        int src;
        logic [63:0] row_buf [2 * VARS_CAP + 1];
        logic [63:0] prior [$];
        len   = row_length();
        rows  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : 0;
        for (int r = 0; r < rows; r++)
        begin
            if (r > 0 && $urandom_range(0, 99) < 70)
            begin
                src = $urandom_range(0, r - 1);
                for (int m = 0; m < len; m++)
                    row_buf[m] = prior[src * len + m];
                for (int m = 0; m < len; m++)
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        case ($urandom_range(0, 3))
                            0: row_buf[m] = row_buf[m] ^ 64'($urandom_range(1, 1 << 20));
                            1: row_buf[m] = row_buf[m] ^ (64'd1 << 63);
                            2: row_buf[m] = row_buf[m] ^ (64'd1 << $urandom_range(40, 52));
                            default: row_buf[m] = random_special();
                        endcase
                    end
                end
                if ($urandom_range(0, 1) == 0)
                    row_buf[0] = random_special();
            end
            else
            begin
                for (int m = 0; m < len; m++)
                    row_buf[m] = ($urandom_range(0, 2) == 0) ? random_special()
                                 : {$urandom, $urandom};
            end
            for (int m = 0; m < len; m++)
                prior.push_back(row_buf[m]);
        end
        for (int e = 0; e < extra; e++)
            prior.push_back({$urandom, $urandom});
        if (prior.size() == 0)
            prior.push_back({$urandom, $urandom});
        foreach (prior[k])
            send_predicted(prior[k], k == prior.size() - 1);
        // A set that causes no verdict may still be busy; let it finish.
        if (rows == 0)
            drain();
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int start_words;
        int sets_here;
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        start_words = words_sent;
        sets_here   = 0;
        while (words_sent - start_words < 18)
        begin
            if (sets_here % 4 == 0)
                reconfigure();
            send_random_set();
            sets_here++;
        end
    endtask

    directed_word_t directed_words [$];

    task automatic add_directed(input logic [63:0] word, input bit fin,
                                input int typed_count, input bit typed_keep);
        directed_word_t d;
        d.word        = word;
        d.fin         = fin;
        d.typed_count = typed_count;
        d.typed_keep  = typed_keep;
        directed_words.push_back(d);
    endtask

    initial
    begin
        verdict_t v;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_NUM_VARS;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.coefficient = '0;
        in_ch.final_req   = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        words_sent        = 0;
        set_count         = 0;
        set_overflow      = 0;
        vars_reg          = 4'd1;
        eps_reg           = '0;
        sender_idle_pct   = 14;
        receiver_idle_pct = 72;

        // Directed transactions with one variable and zero tolerance, as after reset.
        // A lone row is always kept.
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_TWO, 1, 1, 1);
        // A final word that completes no row reports nothing.
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_TWO, 1, 0, 0);
        // Identical columns: the row with the larger constant goes.
        add_directed(D_TWO, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 1, -1, 0);
        // Signed zeros are equal, so a tie removes the later row; opposite signs
        // never match; the trailing partial row is ignored.
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_PZ, 0, -1, 0);
        add_directed(D_PINF, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_NZ, 0, -1, 0);
        add_directed(D_PINF, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_NEG1, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ALL1, 1, -1, 0);
        // A NaN constant makes the constant comparison false: the earlier row goes.
        add_directed(D_QNAN, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 0, -1, 0);
        add_directed(D_ONE, 1, -1, 0);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[k])
        begin
            send_word(directed_words[k].word, directed_words[k].fin);
            if (directed_words[k].typed_count < 0)
            begin
                foreach (fresh_verdicts[n])
                    expected_verdicts.push_back(fresh_verdicts[n]);
            end
            else if (directed_words[k].typed_count == 1)
            begin
                v = '{row_index: '0, keep: directed_words[k].typed_keep, last: 1'b1,
                      overflow: 1'b0};
                expected_verdicts.push_back(v);
            end
        end

        // A relative tolerance of one half lets close values match.
        drain();
        write_register(CFG_TOLERANCE, D_HALF);
        send_predicted(D_ONE, 0);
        send_predicted(64'h3FF4000000000000, 0);
        send_predicted(D_ONE, 0);
        send_predicted(D_ONE, 0);
        send_predicted(D_ONE, 0);
        send_predicted(D_ONE, 1);

        // Full capacity and beyond: a variable count of zero acts as one, so the
        // set holds 64 rows of three words and the last two words are dropped.
        // The sender holds off here until every verdict has come back.
        drain();
        write_register(CFG_NUM_VARS, 64'd0);
        for (int k = 0; k < ROWS_CAP * 3 + 2; k++)
            send_predicted(D_ONE, k == ROWS_CAP * 3 + 1);

        // Random sets under three idle patterns; the last one never idles.
        random_phase(14, 72);
        random_phase(72, 14);
        random_phase(0, 0);

        drain();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
